FILE: rtl/hssq_pkg.sv
// Shared sizes, codes, types and width helpers for the history stack / save queue block.
// No dependencies; every other file in rtl/ imports this package.
package hssq_pkg;

	// Store sizes
	localparam int STACK_DEPTH = 256;
	localparam int QUEUE_DEPTH = 256;
	localparam int ENTRY_BITS  = 32;

	// Port field widths
	localparam int OPCODE_W = 3;
	localparam int ENTRY_W  = 32;
	localparam int KIND_W   = 2;
	localparam int COUNT_W  = 9;

	localparam int STACK_AW = $clog2(STACK_DEPTH);
	localparam int STACK_CW = $clog2(STACK_DEPTH + 1);
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam int WIDE_EW  = (ENTRY_BITS > ENTRY_W) ? ENTRY_BITS : ENTRY_W;
	localparam int WIDE_SCW = (STACK_CW > COUNT_W) ? STACK_CW : COUNT_W;
	localparam int WIDE_QCW = (QUEUE_CW > COUNT_W) ? QUEUE_CW : COUNT_W;

	typedef logic [OPCODE_W-1:0]   opcode_t;
	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [ENTRY_W-1:0]    port_entry_t;
	typedef logic [COUNT_W-1:0]    port_count_t;
	typedef logic [ENTRY_BITS-1:0] entry_t;
	typedef logic [STACK_AW-1:0]   stack_addr_t;
	typedef logic [STACK_CW-1:0]   stack_count_t;
	typedef logic [QUEUE_AW-1:0]   queue_addr_t;
	typedef logic [QUEUE_CW-1:0]   queue_count_t;

	// Opcodes
	localparam opcode_t OP_OPEN    = OPCODE_W'(0);
	localparam opcode_t OP_CURRENT = OPCODE_W'(1);
	localparam opcode_t OP_BACK    = OPCODE_W'(2);
	localparam opcode_t OP_CLEAR   = OPCODE_W'(3);
	localparam opcode_t OP_SAVE    = OPCODE_W'(4);
	localparam opcode_t OP_READ    = OPCODE_W'(5);

	// Result kinds
	localparam kind_t KIND_COUNT  = KIND_W'(0);
	localparam kind_t KIND_HANDLE = KIND_W'(1);
	localparam kind_t KIND_NULL   = KIND_W'(2);
	localparam kind_t KIND_FULL   = KIND_W'(3);

	// Controller to datapath
	typedef struct packed {
		logic capture;  // latch the item and launch the store reads
		logic exec;     // update the stores and load the result register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op_known;  // incoming opcode is one of the six commands
		logic out_free;  // result register can take a new item this cycle
	} dp_status_t;

	function automatic port_entry_t entry_to_port(entry_t e);
		logic [WIDE_EW-1:0] w;
		w = WIDE_EW'(e);
		return w[ENTRY_W-1:0];
	endfunction

	function automatic entry_t port_to_entry(port_entry_t p);
		logic [WIDE_EW-1:0] w;
		w = WIDE_EW'(p);
		return w[ENTRY_BITS-1:0];
	endfunction

	function automatic port_count_t stack_count_to_port(stack_count_t c);
		logic [WIDE_SCW-1:0] w;
		w = WIDE_SCW'(c);
		return w[COUNT_W-1:0];
	endfunction

	function automatic port_count_t queue_count_to_port(queue_count_t c);
		logic [WIDE_QCW-1:0] w;
		w = WIDE_QCW'(c);
		return w[COUNT_W-1:0];
	endfunction

endpackage

FILE: rtl/hssq_if.sv
// Valid/ready channel interfaces for the command and result sides.
// Depends on hssq_pkg.
interface hssq_cmd_if;
	import hssq_pkg::*;

	logic        valid;
	logic        ready;
	opcode_t     opcode;
	port_entry_t entry_id;

	modport source (output valid, output opcode, output entry_id, input ready);
	modport sink   (input valid, input opcode, input entry_id, output ready);
endinterface

interface hssq_rsp_if;
	import hssq_pkg::*;

	logic        valid;
	logic        ready;
	kind_t       kind;
	port_entry_t entry_out;
	port_count_t count_out;

	modport source (output valid, output kind, output entry_out, output count_out, input ready);
	modport sink   (input valid, input kind, input entry_out, input count_out, output ready);
endinterface

FILE: rtl/hssq_ctrl.sv
// Controller for the history stack / save queue: two-state sequencer per item.
// Depends on hssq_pkg.
module hssq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  hssq_pkg::dp_status_t  status,
	output hssq_pkg::ctrl_cmd_t   cmd
);
	import hssq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// unknown opcodes are taken and dropped without a result
				if (cmd_valid && status.op_known) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold until the result register frees up
				if (status.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_exec_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> status.out_free)
		else $error("execute issued while result register is occupied");

	a_capture_then_exec_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC))
		else $error("capture did not move the sequencer to execute");

	a_no_capture_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !cmd.capture)
		else $error("new item captured while one is in flight");
endmodule

FILE: rtl/hssq_dp.sv
// Datapath: stack and queue memories, counts, pointers and the result register.
// Depends on hssq_pkg.
module hssq_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hssq_pkg::ctrl_cmd_t   cmd,
	output hssq_pkg::dp_status_t  status,
	input  hssq_pkg::opcode_t     opcode,
	input  hssq_pkg::port_entry_t entry_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hssq_pkg::kind_t       kind,
	output hssq_pkg::port_entry_t entry_out,
	output hssq_pkg::port_count_t count_out
);
	import hssq_pkg::*;

	// Memories
	entry_t stk_mem [STACK_DEPTH];
	entry_t que_mem [QUEUE_DEPTH];

	// Latched item and registered read data
	opcode_t op_q;
	entry_t  id_q;
	entry_t  stk_rd_q;
	entry_t  que_rd_q;

	// Control state
	stack_count_t scnt_q;
	queue_count_t qcnt_q;
	queue_addr_t  rp_q;
	queue_addr_t  wp_q;

	// Result register
	logic        out_valid_q;
	kind_t       kind_q;
	port_entry_t entry_q;
	port_count_t count_q;

	// Execute-cycle results
	stack_count_t scnt_d;
	queue_count_t qcnt_d;
	queue_addr_t  rp_d;
	queue_addr_t  wp_d;
	logic         stk_we;
	logic         que_we;
	kind_t        res_kind;
	port_entry_t  res_entry;
	port_count_t  res_count;

	stack_count_t stk_rd_cnt;
	stack_addr_t  stk_raddr;

	logic stk_empty;
	logic stk_full;
	logic que_empty;
	logic que_full;

	assign stk_empty = (scnt_q == '0);
	assign stk_full  = (scnt_q == STACK_CW'(STACK_DEPTH));
	assign que_empty = (qcnt_q == '0);
	assign que_full  = (qcnt_q == QUEUE_CW'(QUEUE_DEPTH));

	assign status.op_known = (opcode inside {OP_OPEN, OP_CURRENT, OP_BACK, OP_CLEAR,
		OP_SAVE, OP_READ});
	assign status.out_free = !out_valid_q || out_ready;

	// Back reads the entry below the top; every other read wants the top
	assign stk_rd_cnt = (opcode == OP_BACK) ? (scnt_q - STACK_CW'(2))
		: (scnt_q - STACK_CW'(1));
	assign stk_raddr  = stk_rd_cnt[STACK_AW-1:0];

	function automatic queue_addr_t q_next(queue_addr_t p);
		return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : (p + QUEUE_AW'(1));
	endfunction

	always_comb begin
		scnt_d    = scnt_q;
		qcnt_d    = qcnt_q;
		rp_d      = rp_q;
		wp_d      = wp_q;
		stk_we    = 1'b0;
		que_we    = 1'b0;
		res_kind  = KIND_COUNT;
		res_entry = '0;
		res_count = '0;
		case (op_q)
			OP_OPEN: begin
				if (stk_full) begin
					res_kind = KIND_FULL;
				end else begin
					stk_we    = 1'b1;
					scnt_d    = scnt_q + STACK_CW'(1);
					res_count = stack_count_to_port(scnt_d);
				end
			end
			OP_CURRENT: begin
				if (stk_empty) begin
					res_kind = KIND_NULL;
				end else begin
					res_kind  = KIND_HANDLE;
					res_entry = entry_to_port(stk_rd_q);
				end
			end
			OP_BACK: begin
				if (stk_empty) begin
					res_kind = KIND_NULL;
				end else begin
					scnt_d = scnt_q - STACK_CW'(1);
					if (scnt_q == STACK_CW'(1)) begin
						res_kind = KIND_NULL;
					end else begin
						res_kind  = KIND_HANDLE;
						res_entry = entry_to_port(stk_rd_q);
					end
				end
			end
			OP_CLEAR: begin
				scnt_d    = '0;
				res_count = stack_count_to_port(scnt_q);
			end
			OP_SAVE: begin
				if (!stk_empty && que_full) begin
					res_kind = KIND_FULL;
				end else begin
					if (!stk_empty) begin
						que_we = 1'b1;
						wp_d   = q_next(wp_q);
						qcnt_d = qcnt_q + QUEUE_CW'(1);
					end
					res_count = queue_count_to_port(qcnt_d);
				end
			end
			OP_READ: begin
				if (que_empty) begin
					res_kind = KIND_NULL;
				end else begin
					res_kind  = KIND_HANDLE;
					res_entry = entry_to_port(que_rd_q);
					rp_d      = q_next(rp_q);
					qcnt_d    = qcnt_q - QUEUE_CW'(1);
				end
			end
			default: res_kind = KIND_NULL;
		endcase
	end

	// Stack memory: write on open, read on capture
	always_ff @(posedge clk) begin
		if (cmd.exec && stk_we) begin
			stk_mem[scnt_q[STACK_AW-1:0]] <= id_q;
		end
		if (cmd.capture) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	// Queue memory: write on save, read oldest on capture
	always_ff @(posedge clk) begin
		if (cmd.exec && que_we) begin
			que_mem[wp_q] <= stk_rd_q;
		end
		if (cmd.capture) begin
			que_rd_q <= que_mem[rp_q];
		end
	end

	// Item latch and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			id_q <= port_to_entry(entry_id);
		end
		if (cmd.exec) begin
			kind_q  <= res_kind;
			entry_q <= res_entry;
			count_q <= res_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q      <= '0;
			qcnt_q      <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				scnt_q <= scnt_d;
				qcnt_q <= qcnt_d;
				rp_q   <= rp_d;
				wp_q   <= wp_d;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign entry_out = entry_q;
	assign count_out = count_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scnt_q <= STACK_CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_queue_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(que_empty || que_full) |-> (rp_q == wp_q))
		else $error("queue pointers disagree with queue count");

	a_exec_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed item left no result");
endmodule

FILE: rtl/history_stack_with_save_queue_top.sv
// Top level of the history stack / save queue block.
// Depends on hssq_pkg, hssq_if, hssq_ctrl and hssq_dp.
//
// Browser-style history store of entry handles: a last-in first-out history stack of
// STACK_DEPTH handles and a first-in first-out save queue of QUEUE_DEPTH handles. Each
// command item on the command channel (open, current, back, clear, save, read) yields
// exactly one result item (count, handle, null or store-full) on the result channel; the
// two undefined opcodes are taken and dropped with no result. An item is first taken,
// which launches the reads of the single-port stack and queue memories; then, once the
// registered read data is there, its result is written into the output register. A
// result that waits on the consumer holds the block in the execute state, so only one
// item is in flight and the next command item is taken only after the output register
// has room. Both memories need no clearing after reset: the counts and pointers guard
// every read, so the block takes items as soon as reset is released.
module history_stack_with_save_queue_top (
	input logic        clk,
	input logic        arst_n,
	hssq_cmd_if.sink   command,
	hssq_rsp_if.source result
);
	import hssq_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequence each item: take, then execute
	hssq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (command.valid),
		.cmd_ready (command.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Stores, counts and the result register
	hssq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.opcode    (command.opcode),
		.entry_id  (command.entry_id),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.kind      (result.kind),
		.entry_out (result.entry_out),
		.count_out (result.count_out)
	);
endmodule
